### design/ffa_pkg.sv
`default_nettype none
package ffa_pkg;
   localparam int ADDR_W = 17;
   localparam int LEN_W  = 16;
   localparam int ENT_W  = ADDR_W + LEN_W;

   localparam logic OP_CLAIM = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [0:0] REG_POOL_SIZE = 1'b0;
   localparam logic [0:0] REG_BASE_ADDR = 1'b1;

   localparam logic [15:0] POOL_SIZE_RST = 16'd69;
   localparam logic [15:0] BASE_ADDR_RST = 16'd1000;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } entry_type;
endpackage
`default_nettype wire

### design/ffa_if.sv
`default_nettype none
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] req_size;
   logic [16:0] req_address;
   modport source (output valid, opcode, req_size, req_address, input ready);
   modport sink (input valid, opcode, req_size, req_address, output ready);
endinterface

interface ffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [16:0] value;
   modport source (output valid, status, value, input ready);
   modport sink (input valid, status, value, output ready);
endinterface

interface ffa_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/ffa_ram.sv
`default_nettype none
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/first_fit_allocator_top.sv
// First-fit allocator with coalescing. Free and allocated blocks are kept in
// two address-sorted tables of MAX_BLOCKS entries, each held in a RAM with a
// registered read port. One request is handled at a time. A sequencer walks
// the tables, with each step taking a read-issue state followed by a compare
// or move state. One shared adder forms the end addresses for the split and
// the merge checks. A claim does up to four walks: the free-table search, the
// used-table search, opening a slot in the used table, and closing a slot in
// the free table on an exact fit. A free does the same: the used-table search,
// the free-table search, opening or closing a free slot, and closing the used
// slot. req.ready is high only when idle, when no csr transfer is offered, and
// when the result register is empty or being taken. A csr transfer (index 0
// pool_size, index 1 base_address; other indexes are ignored) and reset both
// reload free entry 0 and the counts. Only entries below the counts are ever
// read, so no clearing pass is needed.
`default_nettype none
module first_fit_allocator_top
   import ffa_pkg::*;
#(
   parameter int MAX_BLOCKS = 32
) (
   input wire logic clock,
   input wire logic reset,
   ffa_req_if.sink   req,
   ffa_rsp_if.source rsp,
   ffa_csr_if.sink   csr
);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_C_RD, S_C_CHK, S_U_RD, S_U_CHK, S_U_SHR, S_U_SHW,
      S_C_WR, S_FC_SHR, S_FC_SHW, S_F_RD, S_F_CHK, S_P_RD, S_P_CHK, S_P_PREV,
      S_P_JP, S_P_DEC, S_FO_SHR, S_FO_SHW, S_UC_SHR, S_UC_SHW, S_DONE
   } state_type;

   state_type state_ff;
   logic [15:0] pool_ff, base_ff;
   logic [CW-1:0] fcnt_ff, ucnt_ff, i_ff, j_ff, k_ff;
   logic op_ff;
   logic [15:0] size_ff;
   logic [ADDR_W-1:0] addr_ff;
   entry_type hit_ff, prev_ff;
   logic [LEN_W-1:0] next_len_ff;
   logic jp_ff, jn_ff;
   logic rsp_valid_ff;
   logic [1:0] status_ff;
   logic [ADDR_W-1:0] value_ff;

   // table ports
   logic f_we, u_we;
   logic [IW-1:0] f_wa, f_ra, u_wa, u_ra;
   entry_type f_wd, u_wd, f_rd, u_rd;

   ffa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_free (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));
   ffa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_used (
      .clock, .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_addr(u_ra), .rd_data(u_rd));

   wire csr_fire = csr.valid && csr.ready;
   wire req_fire = req.valid && req.ready;
   wire rsp_free = !rsp_valid_ff || rsp.ready;
   assign csr.ready = (state_ff == S_IDLE);
   assign req.ready = (state_ff == S_IDLE) && rsp_free && !csr.valid;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.value = value_ff;

   // shared adder: end address of a block, one bit wider so it never wraps
   logic [ADDR_W-1:0] sum_a;
   logic [LEN_W-1:0]  sum_b;
   logic [ADDR_W:0]   sum_y;
   assign sum_y = {1'b0, sum_a} + (ADDR_W + 1)'(sum_b);

   always_comb begin
      f_we = 1'b0; u_we = 1'b0;
      f_wa = '0; u_wa = '0; f_wd = f_rd; u_wd = u_rd;
      f_ra = i_ff[IW-1:0]; u_ra = j_ff[IW-1:0];
      sum_a = hit_ff.start; sum_b = size_ff;
      case (state_ff)
         S_INIT: begin
            // single free block covering the whole pool
            f_we = 1'b1; f_wa = '0;
            f_wd.start = ADDR_W'(base_ff); f_wd.length = pool_ff;
         end
         S_C_RD: f_ra = i_ff[IW-1:0];
         S_U_RD: u_ra = j_ff[IW-1:0];
         S_U_SHR: u_ra = IW'(k_ff - 1'b1);
         S_U_SHW: begin
            u_we = 1'b1; u_wa = k_ff[IW-1:0]; u_wd = u_rd;
         end
         S_C_WR: begin
            // record the claimed block, shrink the free one unless it fits exactly
            u_we = 1'b1; u_wa = j_ff[IW-1:0];
            u_wd.start = hit_ff.start; u_wd.length = size_ff;
            f_wa = i_ff[IW-1:0];
            sum_a = hit_ff.start; sum_b = size_ff;
            if (hit_ff.length != size_ff) begin
               f_we = 1'b1;
               f_wd.start = sum_y[ADDR_W-1:0];
               f_wd.length = hit_ff.length - size_ff;
            end
         end
         S_FC_SHR: f_ra = IW'(k_ff + 1'b1);
         S_FC_SHW: begin
            f_we = 1'b1; f_wa = k_ff[IW-1:0]; f_wd = f_rd;
         end
         S_F_RD: u_ra = j_ff[IW-1:0];
         S_P_RD: f_ra = i_ff[IW-1:0];
         S_P_CHK: begin
            // end of the block being freed
            sum_a = addr_ff; sum_b = hit_ff.length;
         end
         S_P_PREV: f_ra = IW'(i_ff - 1'b1);
         S_P_JP: begin
            // end of the free block just below
            sum_a = f_rd.start; sum_b = f_rd.length;
         end
         S_P_DEC: begin
            f_we = jp_ff || jn_ff;
            if (jp_ff) begin
               f_wa = IW'(i_ff - 1'b1);
               f_wd.start = prev_ff.start;
               f_wd.length = prev_ff.length + hit_ff.length
                  + (jn_ff ? next_len_ff : LEN_W'(0));
            end else begin
               f_wa = i_ff[IW-1:0];
               f_wd.start = addr_ff;
               f_wd.length = next_len_ff + hit_ff.length;
            end
         end
         S_FO_SHR: begin
            if (k_ff > i_ff) begin
               f_ra = IW'(k_ff - 1'b1);
            end else begin
               // slot is open: place the freed block
               f_we = 1'b1; f_wa = i_ff[IW-1:0];
               f_wd.start = addr_ff; f_wd.length = hit_ff.length;
            end
         end
         S_FO_SHW: begin
            f_we = 1'b1; f_wa = k_ff[IW-1:0]; f_wd = f_rd;
         end
         S_UC_SHR: u_ra = IW'(k_ff + 1'b1);
         S_UC_SHW: begin
            u_we = 1'b1; u_wa = k_ff[IW-1:0]; u_wd = u_rd;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pool_ff <= POOL_SIZE_RST; base_ff <= BASE_ADDR_RST;
         fcnt_ff <= '0; ucnt_ff <= '0;
      end else begin
         case (state_ff)
            S_INIT: begin
               fcnt_ff <= (pool_ff != '0) ? CW'(1) : '0;
               ucnt_ff <= '0;
               state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (csr_fire) begin
                  // a write to pool_size or base_address reloads both tables; other indexes are ignored
                  if (csr.index == 32'(REG_POOL_SIZE)) begin
                     pool_ff <= csr.data; state_ff <= S_INIT;
                  end else if (csr.index == 32'(REG_BASE_ADDR)) begin
                     base_ff <= csr.data; state_ff <= S_INIT;
                  end
               end else if (req_fire) begin
                  op_ff <= req.opcode; size_ff <= req.req_size;
                  addr_ff <= req.req_address; i_ff <= '0; j_ff <= '0;
                  if (req.opcode == OP_CLAIM) begin
                     if (req.req_size == '0) begin
                        status_ff <= ST_MISS; state_ff <= S_DONE;
                     end else state_ff <= S_C_RD;
                  end else if (req.req_address < ADDR_W'(base_ff) ||
                        req.req_address >= ADDR_W'(base_ff) + ADDR_W'(pool_ff)) begin
                     status_ff <= ST_RANGE; state_ff <= S_DONE;
                  end else state_ff <= S_F_RD;
               end
            end
            // claim: first free block that is large enough
            S_C_RD: begin
               if (i_ff >= fcnt_ff) begin
                  status_ff <= ST_MISS; state_ff <= S_DONE;
               end else state_ff <= S_C_CHK;
            end
            S_C_CHK: begin
               if (f_rd.length >= size_ff) begin
                  if (ucnt_ff >= MAXC) begin
                     status_ff <= ST_FULL; state_ff <= S_DONE;
                  end else begin
                     hit_ff <= f_rd; state_ff <= S_U_RD;
                  end
               end else begin
                  i_ff <= i_ff + 1'b1; state_ff <= S_C_RD;
               end
            end
            // claim: sorted position in the used table
            S_U_RD: begin
               if (j_ff >= ucnt_ff) begin
                  k_ff <= ucnt_ff; state_ff <= S_U_SHR;
               end else state_ff <= S_U_CHK;
            end
            S_U_CHK: begin
               if (u_rd.start > hit_ff.start) begin
                  k_ff <= ucnt_ff; state_ff <= S_U_SHR;
               end else begin
                  j_ff <= j_ff + 1'b1; state_ff <= S_U_RD;
               end
            end
            S_U_SHR: state_ff <= (k_ff > j_ff) ? S_U_SHW : S_C_WR;
            S_U_SHW: begin
               k_ff <= k_ff - 1'b1; state_ff <= S_U_SHR;
            end
            S_C_WR: begin
               ucnt_ff <= ucnt_ff + 1'b1;
               status_ff <= ST_OK;
               value_ff <= hit_ff.start;
               if (hit_ff.length == size_ff) begin
                  k_ff <= i_ff; state_ff <= S_FC_SHR;
               end else state_ff <= S_DONE;
            end
            // close free slot k: used by an exact claim and a two-sided merge
            S_FC_SHR: begin
               if (k_ff + 1'b1 < fcnt_ff) begin
                  state_ff <= S_FC_SHW;
               end else begin
                  fcnt_ff <= fcnt_ff - 1'b1;
                  if (op_ff == OP_FREE) begin
                     k_ff <= j_ff; state_ff <= S_UC_SHR;
                  end else state_ff <= S_DONE;
               end
            end
            S_FC_SHW: begin
               k_ff <= k_ff + 1'b1; state_ff <= S_FC_SHR;
            end
            // free: find the allocated block
            S_F_RD: begin
               if (j_ff >= ucnt_ff) begin
                  status_ff <= ST_MISS; state_ff <= S_DONE;
               end else state_ff <= S_F_CHK;
            end
            S_F_CHK: begin
               if (u_rd.start == addr_ff) begin
                  hit_ff <= u_rd; state_ff <= S_P_RD;
               end else begin
                  j_ff <= j_ff + 1'b1; state_ff <= S_F_RD;
               end
            end
            // free: first free block above, and whether it touches
            S_P_RD: begin
               if (i_ff >= fcnt_ff) begin
                  jn_ff <= 1'b0; state_ff <= S_P_PREV;
               end else state_ff <= S_P_CHK;
            end
            S_P_CHK: begin
               if (f_rd.start > addr_ff) begin
                  next_len_ff <= f_rd.length;
                  jn_ff <= (sum_y == {1'b0, f_rd.start});
                  state_ff <= S_P_PREV;
               end else begin
                  i_ff <= i_ff + 1'b1; state_ff <= S_P_RD;
               end
            end
            S_P_PREV: begin
               if (i_ff == '0) begin
                  jp_ff <= 1'b0; state_ff <= S_P_DEC;
               end else state_ff <= S_P_JP;
            end
            S_P_JP: begin
               prev_ff <= f_rd;
               jp_ff <= (sum_y == {1'b0, addr_ff});
               state_ff <= S_P_DEC;
            end
            S_P_DEC: begin
               if (jp_ff && jn_ff) begin
                  k_ff <= i_ff; state_ff <= S_FC_SHR;
               end else if (jp_ff || jn_ff) begin
                  k_ff <= j_ff; state_ff <= S_UC_SHR;
               end else if (fcnt_ff >= MAXC) begin
                  status_ff <= ST_FULL; state_ff <= S_DONE;
               end else begin
                  k_ff <= fcnt_ff; state_ff <= S_FO_SHR;
               end
            end
            // open free slot i for a block with no neighbor
            S_FO_SHR: begin
               if (k_ff > i_ff) begin
                  state_ff <= S_FO_SHW;
               end else begin
                  fcnt_ff <= fcnt_ff + 1'b1;
                  k_ff <= j_ff; state_ff <= S_UC_SHR;
               end
            end
            S_FO_SHW: begin
               k_ff <= k_ff - 1'b1; state_ff <= S_FO_SHR;
            end
            // drop the freed entry from the used table
            S_UC_SHR: begin
               if (k_ff + 1'b1 < ucnt_ff) begin
                  state_ff <= S_UC_SHW;
               end else begin
                  ucnt_ff <= ucnt_ff - 1'b1;
                  status_ff <= ST_OK;
                  value_ff <= {1'b0, hit_ff.length};
                  state_ff <= S_DONE;
               end
            end
            S_UC_SHW: begin
               k_ff <= k_ff + 1'b1; state_ff <= S_UC_SHR;
            end
            S_DONE: begin
               if (status_ff != ST_OK) value_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result register: loaded at the end of a request, cleared on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == S_IDLE) else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (fcnt_ff <= MAXC) && (ucnt_ff <= MAXC)) else $error("count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable({rsp.status, rsp.value}))
      else $error("result changed while waiting");
endmodule
`default_nettype wire
